/* rtl/core/latest_value_slot_manager_assert.svh */
// Assertion macros for the latest-value slot manager.
`ifndef LATEST_VALUE_SLOT_MANAGER_ASSERT_SVH
`define LATEST_VALUE_SLOT_MANAGER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define LVSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slot manager check failed");

// Antecedent implies consequent in the next cycle.
`define LVSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slot manager check failed");

`endif

/* rtl/core/lvsm_pkg.sv */
// Types and constants of the latest-value slot manager.
`timescale 1ns / 1ps
`default_nettype none

package lvsm_pkg;

    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STAMP_W    = 64;

    localparam logic [1:0] CMD_OLDEST  = 2'd0;
    localparam logic [1:0] CMD_NEWEST  = 2'd1;
    localparam logic [1:0] CMD_CLAIM   = 2'd2;
    localparam logic [1:0] CMD_PUBLISH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY = 2'd1;

    localparam logic [3:0]         ACTIVE_RESET = 4'd8;
    localparam logic [31:0]        EXPIRY_RESET = 32'd2000000;
    localparam logic [STAMP_W-1:0] MARK_WRITING = {STAMP_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FIN   = 4'b0100,
        ST_CLAIM = 4'b1000
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/latest_value_slot_manager.sv */
// Latest-value slot manager: per-slot timestamps in a memory, scanned by pick commands.
//
//  Channel   Signals                                         Handshake
//  command   start, busy, i_cmd, i_slot, i_stamp, i_now      start && !busy
//  result    o_done, o_chosen_slot, o_success, o_chosen_stamp  o_done, one cycle
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data valid && ready
//
// A publish, a claim of a slot out of range and a pick with no active slot answer in the
// cycle after acceptance; any other claim passes through ST_CLAIM first. Any other pick
// walks the active slots, their count capped at SLOTS, in ST_SCAN and then ends in ST_FIN,
// as the single memory read port delivers one stamp per cycle to the compare unit. Reset
// clears every slot through its valid bit at once, so no clearing pass is needed. Results
// cannot be stalled; busy is high while a claim or a pick is in progress.
`timescale 1ns / 1ps
`default_nettype none

module latest_value_slot_manager #(
    parameter int SLOTS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          i_cmd,
    input  wire logic [3:0]                          i_slot,
    input  wire logic [lvsm_pkg::STAMP_W-1:0]        i_stamp,
    input  wire logic [lvsm_pkg::STAMP_W-1:0]        i_now,
    output logic                                     o_done,
    output logic [3:0]                               o_chosen_slot,
    output logic                                     o_success,
    output logic [lvsm_pkg::STAMP_W-1:0]             o_chosen_stamp,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lvsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lvsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import lvsm_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    logic [STAMP_W-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]   r_valid;

    t_state             r_state, n_state;
    logic [3:0]         r_active;
    logic [31:0]        r_expiry;
    logic [1:0]         r_cmd, n_cmd;
    logic [AW-1:0]      r_slot, n_slot;
    logic [STAMP_W-1:0] r_now, n_now;
    logic [AW-1:0]      r_cidx, n_cidx;
    logic [AW-1:0]      r_last, n_last;
    logic [STAMP_W-1:0] r_best, n_best;
    logic [3:0]         r_pick, n_pick;
    logic               r_found, n_found;
    logic [STAMP_W-1:0] r_rdata;
    logic               r_rvalid;
    logic               r_done, n_done;
    logic [3:0]         r_oslot, n_oslot;
    logic               r_ook, n_ook;
    logic [STAMP_W-1:0] r_ostamp, n_ostamp;

    logic [CNT_W-1:0]   live;
    logic               accept;
    logic               in_range;
    logic [STAMP_W-1:0] eff;
    logic [AW-1:0]      raddr;
    logic               w_en;
    logic [AW-1:0]      waddr;
    logic [STAMP_W-1:0] wdata;
    logic               fresh;

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_done         = r_done;
    assign o_chosen_slot  = r_oslot;
    assign o_success      = r_ook;
    assign o_chosen_stamp = r_ostamp;

    assign live     = ({1'b0, r_active} > SLOTS_C) ? SLOTS_C : {1'b0, r_active};
    assign accept   = start && !busy;
    assign in_range = ({1'b0, i_slot} < live);
    assign eff      = r_rvalid ? r_rdata : '0;
    assign fresh    = (r_expiry == 32'd0) || ((r_now - r_best) <= {32'd0, r_expiry});

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_slot   = r_slot;
        n_now    = r_now;
        n_cidx   = r_cidx;
        n_last   = r_last;
        n_best   = r_best;
        n_pick   = r_pick;
        n_found  = r_found;
        n_done   = 1'b0;
        n_oslot  = r_oslot;
        n_ook    = r_ook;
        n_ostamp = r_ostamp;
        raddr    = i_slot[AW-1:0];
        w_en     = 1'b0;
        waddr    = i_slot[AW-1:0];
        wdata    = i_stamp;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd  = i_cmd;
                    n_slot = i_slot[AW-1:0];
                    n_now  = i_now;
                    case (i_cmd)
                        CMD_OLDEST, CMD_NEWEST: begin
                            raddr = '0;
                            if (live == '0) begin
                                n_done   = 1'b1;
                                n_oslot  = 4'd0;
                                n_ook    = 1'b0;
                                n_ostamp = '0;
                            end else begin
                                n_state = ST_SCAN;
                                n_cidx  = '0;
                                n_last  = AW'(live - 1'b1);
                                n_best  = '0;
                                n_pick  = 4'd0;
                                n_found = 1'b0;
                            end
                        end
                        CMD_CLAIM: begin
                            if (in_range) begin
                                n_state = ST_CLAIM;
                            end else begin
                                n_done   = 1'b1;
                                n_oslot  = 4'd0;
                                n_ook    = 1'b0;
                                n_ostamp = '0;
                            end
                        end
                        default: begin
                            w_en     = in_range;
                            n_done   = 1'b1;
                            n_oslot  = 4'd0;
                            n_ook    = in_range;
                            n_ostamp = '0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                raddr = AW'(r_cidx + 1'b1);
                if (r_cmd == CMD_OLDEST) begin
                    if ((r_cidx == '0) || (eff < r_best)) begin
                        n_best = eff;
                        n_pick = 4'(r_cidx);
                    end
                    n_found = 1'b1;
                end else if ((eff != '0) && (eff != MARK_WRITING) && (eff >= r_best)) begin
                    n_best  = eff;
                    n_pick  = 4'(r_cidx);
                    n_found = 1'b1;
                end
                if (r_cidx == r_last) begin
                    n_state = ST_FIN;
                end else begin
                    n_cidx = AW'(r_cidx + 1'b1);
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                if (r_cmd == CMD_OLDEST) begin
                    n_oslot  = r_pick;
                    n_ook    = 1'b1;
                    n_ostamp = '0;
                end else if (r_found && fresh) begin
                    n_oslot  = r_pick;
                    n_ook    = 1'b1;
                    n_ostamp = r_best;
                end else begin
                    n_oslot  = 4'd0;
                    n_ook    = 1'b0;
                    n_ostamp = '0;
                end
            end
            ST_CLAIM: begin
                n_state  = ST_IDLE;
                n_done   = 1'b1;
                waddr    = r_slot;
                wdata    = MARK_WRITING;
                w_en     = (eff != MARK_WRITING);
                n_oslot  = 4'd0;
                n_ook    = (eff != MARK_WRITING);
                n_ostamp = '0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata  <= r_mem[raddr];
        r_rvalid <= r_valid[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_done   <= 1'b0;
            r_active <= ACTIVE_RESET;
            r_expiry <= EXPIRY_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ACTIVE: r_active <= i_cfg_data[3:0];
                    CFG_EXPIRY: r_expiry <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_slot   <= n_slot;
        r_now    <= n_now;
        r_cidx   <= n_cidx;
        r_last   <= n_last;
        r_best   <= n_best;
        r_pick   <= n_pick;
        r_found  <= n_found;
        r_oslot  <= n_oslot;
        r_ook    <= n_ook;
        r_ostamp <= n_ostamp;
    end

`include "latest_value_slot_manager_assert.svh"

    `LVSM_ASSERT_NEXT(a_accept_progress, start && !busy, o_done || busy)
    `LVSM_ASSERT_NOW(a_fail_zero, o_done && !o_success, o_chosen_slot == 4'd0 && o_chosen_stamp == '0)
    `LVSM_ASSERT_NOW(a_scan_bound, r_state == ST_SCAN, r_cidx <= r_last)
    `LVSM_ASSERT_NOW(a_write_src, w_en, r_state == ST_CLAIM || (start && !busy))

endmodule

`default_nettype wire
